// ===== rtl/sphere_box_collision_test_macros.svh =====
// Assertion macros shared by the checker of the sphere and box overlap block.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef SPHERE_BOX_COLLISION_TEST_MACROS_SVH
`define SPHERE_BOX_COLLISION_TEST_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define SBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbc assertion failed");

// The expression must hold at every clock edge outside reset.
`define SBC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sbc assertion failed");

`endif

// ===== rtl/sbc_pkg.sv =====
// Package for the sphere and box overlap block: widths, pair kind codes, types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int CoordW = 16;          // signed Q8.8 center coordinate
  localparam int SizeW  = 15;          // unsigned Q7.8 radius or half extent
  localparam int DiffW  = 18;          // distance from a center to a box face
  localparam int SqW    = 34;          // square of a distance, unsigned
  localparam int SumW   = SqW + 2;     // sum of up to three squares
  localparam int BaseW  = 16;          // radius, or sum of two radii
  localparam int RrW    = 2 * BaseW;   // square of the radius term

  localparam logic [1:0] KIND_BALL_BALL = 2'd0;
  localparam logic [1:0] KIND_CUBE_BALL = 2'd1;
  localparam logic [1:0] KIND_CUBE_CUBE = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [SizeW-1:0]         size_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic [SqW-1:0]           sq_t;
  typedef logic [BaseW-1:0]         base_t;
  typedef logic [RrW-1:0]           rr_t;

  // Per-request decision flags that travel down the pipeline with the squares.
  typedef struct packed {
    logic       ball_ball;
    logic       cube_ball;
    logic       reject;
    logic       face;
    logic [2:0] in_box;
  } sbc_flags_t;

endpackage

// ===== rtl/sphere_box_collision_test.sv =====
// Sphere/sphere and box/sphere overlap test, four register stages deep.
// out_valid rises once a taken request has passed the input, face-distance, square and result registers.
// Throughput: one request every cycle; busy stays low, since the four stages
// (input, face distances, squares, result) each hold their own request.
// The receiver cannot stall. Synchronous active-low reset empties the pipeline.
`timescale 1ns / 1ps

module sphere_box_collision_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_pair_kind,
  input  sbc_pkg::coord_t     in_first_x,
  input  sbc_pkg::coord_t     in_first_y,
  input  sbc_pkg::coord_t     in_first_z,
  input  sbc_pkg::size_t      in_first_size_x,
  input  sbc_pkg::size_t      in_first_size_y,
  input  sbc_pkg::size_t      in_first_size_z,
  input  sbc_pkg::coord_t     in_second_x,
  input  sbc_pkg::coord_t     in_second_y,
  input  sbc_pkg::coord_t     in_second_z,
  input  sbc_pkg::size_t      in_second_radius,
  output logic                out_valid,
  output logic                out_overlap
);
  import sbc_pkg::*;

  // Stage 0: captured request.
  logic       v0_r;
  logic [1:0] kind_r;
  coord_t     c_r [3];
  size_t      h_r [3];
  coord_t     p_r [3];
  size_t      r_r;

  // Stage 1: distances and flags.
  logic       v1_r;
  diff_t      d0_nxt [3], d1_nxt [3];
  diff_t      d0_r [3], d1_r [3];
  base_t      base_nxt, base_r;
  sbc_flags_t flags_nxt, flags1_r;

  // Stage 2: squares.
  logic       v2_r;
  sq_t        sq0_nxt [3], sq1_nxt [3];
  sq_t        sq0_r [3], sq1_r [3];
  rr_t        rr_nxt, rr_r;
  sbc_flags_t flags2_r;

  // Stage 3: result.
  logic       out_valid_r;
  logic       hit_nxt, out_overlap_r;

  logic signed [2*DiffW-1:0] prod0 [3], prod1 [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= start && !busy;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= in_pair_kind;
      c_r[0] <= in_first_x;
      c_r[1] <= in_first_y;
      c_r[2] <= in_first_z;
      h_r[0] <= in_first_size_x;
      h_r[1] <= in_first_size_y;
      h_r[2] <= in_first_size_z;
      p_r[0] <= in_second_x;
      p_r[1] <= in_second_y;
      p_r[2] <= in_second_z;
      r_r    <= in_second_radius;
    end
  end

  sbc_prep u_prep (
    .pair_kind (kind_r),
    .c         (c_r),
    .h         (h_r),
    .p         (p_r),
    .r         (r_r),
    .d0        (d0_nxt),
    .d1        (d1_nxt),
    .sq_base   (base_nxt),
    .flags     (flags_nxt)
  );

  always_ff @(posedge clk) begin
    d0_r     <= d0_nxt;
    d1_r     <= d1_nxt;
    base_r   <= base_nxt;
    flags1_r <= flags_nxt;
  end

  // Squares are exact: every distance fits in DiffW bits, its square in SqW.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod0[a]   = d0_r[a] * d0_r[a];
      prod1[a]   = d1_r[a] * d1_r[a];
      sq0_nxt[a] = prod0[a][SqW-1:0];
      sq1_nxt[a] = prod1[a][SqW-1:0];
    end
    rr_nxt = base_r * base_r;
  end

  always_ff @(posedge clk) begin
    sq0_r    <= sq0_nxt;
    sq1_r    <= sq1_nxt;
    rr_r     <= rr_nxt;
    flags2_r <= flags1_r;
  end

  sbc_decide u_decide (
    .sq0   (sq0_r),
    .sq1   (sq1_r),
    .rr    (rr_r),
    .flags (flags2_r),
    .hit   (hit_nxt)
  );

  always_ff @(posedge clk) begin
    out_overlap_r <= hit_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule

// ===== rtl/sbc_prep.sv =====
// First compute stage: distances to the box faces, slab flags and the radius term.
// Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_prep (
  input  logic [1:0]          pair_kind,
  input  sbc_pkg::coord_t     c [3],
  input  sbc_pkg::size_t      h [3],
  input  sbc_pkg::coord_t     p [3],
  input  sbc_pkg::size_t      r,
  output sbc_pkg::diff_t      d0 [3],
  output sbc_pkg::diff_t      d1 [3],
  output sbc_pkg::base_t      sq_base,
  output sbc_pkg::sbc_flags_t flags
);
  import sbc_pkg::*;

  logic signed [DiffW:0] c_e, h_e, p_e, r_e, lo, hi;
  logic [2:0] rej;
  logic       is_ball;

  always_comb begin
    is_ball = (pair_kind == KIND_BALL_BALL);
    rej     = '0;
    flags   = '0;
    for (int a = 0; a < 3; a++) begin
      c_e = (DiffW + 1)'(c[a]);
      p_e = (DiffW + 1)'(p[a]);
      h_e = $signed({{(DiffW + 1 - SizeW){1'b0}}, h[a]});
      r_e = $signed({{(DiffW + 1 - SizeW){1'b0}}, r});
      lo  = c_e - h_e;
      hi  = c_e + h_e;
      // Outside the box grown by the radius on this axis: no overlap at all.
      rej[a]          = (p_e <= lo - r_e) || (p_e >= hi + r_e);
      flags.in_box[a] = (p_e > lo) && (p_e < hi);
      // For two balls the first slot carries the center distance instead.
      d0[a] = is_ball ? DiffW'(c_e - p_e) : DiffW'(p_e - lo);
      d1[a] = DiffW'(p_e - hi);
    end
    flags.ball_ball = is_ball;
    flags.cube_ball = (pair_kind == KIND_CUBE_BALL);
    flags.reject    = |rej;
    // Once not rejected, every axis lies within the grown range, so a face slab
    // only needs the center strictly inside the box on two axes.
    flags.face = (flags.in_box[0] & flags.in_box[1]) |
                 (flags.in_box[0] & flags.in_box[2]) |
                 (flags.in_box[1] & flags.in_box[2]);
    sq_base = is_ball ? (BaseW'(h[0]) + BaseW'(r)) : BaseW'(r);
  end

endmodule

// ===== rtl/sbc_decide.sv =====
// Last compute stage: edge, corner and center distance compares on squared terms.
// Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_decide (
  input  sbc_pkg::sq_t        sq0 [3],
  input  sbc_pkg::sq_t        sq1 [3],
  input  sbc_pkg::rr_t        rr,
  input  sbc_pkg::sbc_flags_t flags,
  output logic                hit
);
  import sbc_pkg::*;

  sq_t             ends [3][2];
  logic [SumW-1:0] rr_e, sum;
  logic            ball_hit, edge_hit, corner_hit;
  int              b, d;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ends[a][0] = sq0[a];
      ends[a][1] = sq1[a];
    end
    rr_e = SumW'(rr);

    sum      = SumW'(sq0[0]) + SumW'(sq0[1]) + SumW'(sq0[2]);
    ball_hit = sum < rr_e;

    // An edge along one axis counts only while the center is inside that span.
    edge_hit = 1'b0;
    for (int a = 0; a < 3; a++) begin
      b = (a == 2) ? 0 : a + 1;
      d = (a == 0) ? 2 : a - 1;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (flags.in_box[a] &&
              (SumW'(ends[b][i]) + SumW'(ends[d][j]) < rr_e)) begin
            edge_hit = 1'b1;
          end
        end
      end
    end

    corner_hit = 1'b0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          if (SumW'(ends[0][i]) + SumW'(ends[1][j]) + SumW'(ends[2][k]) < rr_e) begin
            corner_hit = 1'b1;
          end
        end
      end
    end

    priority if (flags.ball_ball) begin
      hit = ball_hit;
    end else if (flags.cube_ball) begin
      hit = !flags.reject && (flags.face || edge_hit || corner_hit);
    end else begin
      hit = 1'b0;
    end
  end

endmodule

// ===== rtl/sbc_checker.sv =====
// Port-level checker for the sphere and box overlap block, bound to its top level.
// Depends on sbc_pkg and sphere_box_collision_test_macros.svh.
`timescale 1ns / 1ps
`include "sphere_box_collision_test_macros.svh"

module sbc_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic [1:0]      in_pair_kind,
  input sbc_pkg::size_t  in_first_size_x,
  input sbc_pkg::size_t  in_second_radius,
  input logic            out_valid,
  input logic            out_overlap
);
  import sbc_pkg::*;

  logic [3:0] rst_hist_r;
  logic       req_take;
  logic       point_balls;

  // Shift register of the reset level, newest sample in bit 0.
  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[2:0], rst_n};
  end

  assign req_take    = start && !busy;
  assign point_balls = req_take && in_pair_kind == KIND_BALL_BALL &&
                       in_first_size_x == '0 && in_second_radius == '0;

  // The pipeline never pushes back on the sender.
  `SBC_ASSERT_ALWAYS(a_never_busy, !busy)

  // Every request yields one strobe, checked against the request delayed through the pipeline, and no other strobes.
  `SBC_ASSERT_IMPL(a_strobe_latency, &rst_hist_r, out_valid == $past(req_take, 4))

  // Two boxes, and the unused kind, never report overlap.
  `SBC_ASSERT_IMPL(a_box_box_clear, out_valid && $past(in_pair_kind[1], 4), !out_overlap)

  // Two balls of zero radius can never overlap under the strict compare.
  `SBC_ASSERT_IMPL(a_point_balls_clear, out_valid && $past(point_balls, 4), !out_overlap)

endmodule

bind sphere_box_collision_test sbc_checker u_sbc_checker (.*);
